>>> hw/rtl/sensor_frame_gather_argmax_unit_defines.svh
// assertion helpers for the rtl scan unit
`ifndef SENSOR_FRAME_GATHER_ARGMAX_UNIT_DEFINES_SVH
`define SENSOR_FRAME_GATHER_ARGMAX_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SFGA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfga assertion failed");

// next-cycle implication, disabled during reset
`define SFGA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfga assertion failed");

`endif

>>> hw/rtl/sfga_pkg.sv
`timescale 1ns / 1ps

package sfga_pkg;

    // board and channel geometry
    localparam int BOARDS         = 2;
    localparam int CH_PER_BOARD   = 8;
    localparam int TOTAL_CH       = BOARDS * CH_PER_BOARD;
    localparam int BOARD_W        = 1;
    localparam int IDX_W          = $clog2(TOTAL_CH);
    localparam int CNT_W          = $clog2(TOTAL_CH + 1);
    localparam int VAL_W          = 16;

    // frame layout: two reference bytes, then two bytes per channel
    localparam int FRAME_DATA_END = 2 + 2 * CH_PER_BOARD;
    localparam int POS_W          = $clog2(FRAME_DATA_END + 1);

    localparam logic [BOARDS-1:0] BOARD_MASK_RST = '1;

    typedef struct packed {
        logic [BOARD_W-1:0] board_id;
        logic [7:0]         data_byte;
        logic               frame_end;
    } t_in_word;

    typedef struct packed {
        logic [3:0]       max_channel;
        logic [VAL_W-1:0] max_value;
    } t_out_word;

    // reading store write port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [VAL_W-1:0] data;
    } t_wr_req;

    // reading store read port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_rd_req;

    // scan launch from the frame parser
    typedef struct packed {
        logic              start;
        logic [BOARDS-1:0] en_mask;
    } t_scan_ctrl;

endpackage

>>> hw/rtl/sfga_store.sv
`timescale 1ns / 1ps

module sfga_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sfga_pkg::t_wr_req           i_wr,
    input  sfga_pkg::t_rd_req           i_rd,
    output logic [sfga_pkg::VAL_W-1:0]  o_rd_data
);

    logic [sfga_pkg::VAL_W-1:0]    r_mem [sfga_pkg::TOTAL_CH];
    logic [sfga_pkg::TOTAL_CH-1:0] r_vld;
    logic [sfga_pkg::VAL_W-1:0]    r_rd_data;

    // per-entry written flags, an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_vld[i_rd.addr] ? r_mem[i_rd.addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/sfga_scan.sv
`timescale 1ns / 1ps
`include "sensor_frame_gather_argmax_unit_defines.svh"

module sfga_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sfga_pkg::t_scan_ctrl        i_ctrl,
    output logic                        o_busy,
    output sfga_pkg::t_rd_req           o_rd,
    input  logic [sfga_pkg::VAL_W-1:0]  i_rd_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output sfga_pkg::t_out_word         o_out_word
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                     r_state,    n_state;
    logic [sfga_pkg::CNT_W-1:0]     r_issue,    n_issue;
    logic                           r_pend,     n_pend;
    logic [sfga_pkg::IDX_W-1:0]     r_pend_idx, n_pend_idx;
    logic [sfga_pkg::VAL_W-1:0]     r_best_val, n_best_val;
    logic [sfga_pkg::IDX_W-1:0]     r_best_ch,  n_best_ch;
    logic [sfga_pkg::BOARDS-1:0]    r_en,       n_en;
    logic                           r_out_vld,  n_out_vld;
    sfga_pkg::t_out_word            r_out_word, n_out_word;
    logic                           w_rd_en;
    logic [sfga_pkg::BOARD_W-1:0]   w_pend_board;
    logic [sfga_pkg::BOARD_W-1:0]   w_best_board;
    logic                           w_take;

    // board that owns the word coming back from the store
    assign w_pend_board = sfga_pkg::BOARD_W'(r_pend_idx
                          / sfga_pkg::IDX_W'(sfga_pkg::CH_PER_BOARD));
    assign w_best_board = sfga_pkg::BOARD_W'(r_best_ch
                          / sfga_pkg::IDX_W'(sfga_pkg::CH_PER_BOARD));

    // shared compare unit: strictly larger wins, so the first maximum stays
    assign w_take = r_pend && r_en[w_pend_board] && (i_rd_data > r_best_val);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_issue    = r_issue;
        n_pend     = 1'b0;
        n_pend_idx = r_issue[sfga_pkg::IDX_W-1:0];
        n_best_val = r_best_val;
        n_best_ch  = r_best_ch;
        n_en       = r_en;
        n_out_vld  = r_out_vld;
        n_out_word = r_out_word;
        w_rd_en    = 1'b0;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        if (w_take) begin
            n_best_val = i_rd_data;
            n_best_ch  = r_pend_idx;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_ctrl.start) begin
                    n_state    = ST_RUN;
                    n_issue    = '0;
                    n_best_val = '0;
                    n_best_ch  = '0;
                    n_en       = i_ctrl.en_mask;
                end
            end
            ST_RUN: begin
                if (r_issue != sfga_pkg::CNT_W'(sfga_pkg::TOTAL_CH)) begin
                    w_rd_en = 1'b1;
                    n_pend  = 1'b1;
                    n_issue = r_issue + 1'b1;
                end else if (!r_pend) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld              = 1'b1;
                    n_out_word.max_channel = 4'(r_best_ch);
                    n_out_word.max_value   = r_best_val;
                    n_state                = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pend     <= 1'b0;
            r_out_vld  <= 1'b0;
            r_best_val <= '0;
        end else begin
            r_state    <= n_state;
            r_pend     <= n_pend;
            r_out_vld  <= n_out_vld;
            r_best_val <= n_best_val;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_issue    <= n_issue;
        r_pend_idx <= n_pend_idx;
        r_best_ch  <= n_best_ch;
        r_en       <= n_en;
        r_out_word <= n_out_word;
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_rd.en     = w_rd_en;
    assign o_rd.addr   = r_issue[sfga_pkg::IDX_W-1:0];
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    // a scan is only launched from idle
    `SFGA_ASSERT_SAME(a_start_idle, i_clk, i_rst_n, i_ctrl.start, r_state == ST_IDLE)
    // store reads are issued only while scanning
    `SFGA_ASSERT_SAME(a_rd_in_run, i_clk, i_rst_n, w_rd_en, r_state == ST_RUN)
    // a nonzero best always belongs to an enabled board
    `SFGA_ASSERT_SAME(a_best_enabled, i_clk, i_rst_n, r_best_val != '0, r_en[w_best_board])
    // a finished scan with room at the output publishes a word
    `SFGA_ASSERT_NEXT(a_done_pub, i_clk, i_rst_n,
        (r_state == ST_DONE) && (!r_out_vld || i_out_ready), r_out_vld && (r_state == ST_IDLE))

endmodule

>>> hw/rtl/sensor_frame_gather_argmax_unit.sv
`timescale 1ns / 1ps
// Gathers channel readings from sensor board frames and reports the brightest channel.
// Input channel (i_in_valid / o_in_ready / i_in_word): one frame byte per word, tagged
//   with its board and a frame_end flag. Readings of enabled boards go into a 16-entry
//   store as their high byte arrives.
// When the last enabled board closes its frame, the round is complete and a single
//   compare unit walks the store one channel per cycle. The result word appears on
//   o_out_valid / o_out_word after the closing byte is accepted and the store reads,
//   one read pipeline stage, a wrap-up step and the output register load follow.
// Throughput: one byte word per cycle, except the closing word of a round, after which
//   o_in_ready stays low while the store is scanned and until the result is loaded.
// Configuration (i_cfg_valid / o_cfg_ready / i_cfg_data): the board enable mask, taken
//   while no scan runs; boards it disables lose their fresh flag.
// Reset (synchronous, i_rst_n low): all readings read as zero, enable mask is all
//   ones, no board is fresh, the frame position restarts.
// Output stall: the result stays in its register until taken; the next round can
//   gather meanwhile, and a finished scan holds until the register frees up.
module sensor_frame_gather_argmax_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  sfga_pkg::t_in_word             i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output sfga_pkg::t_out_word            o_out_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sfga_pkg::BOARDS-1:0]    i_cfg_data
);

    logic [sfga_pkg::BOARDS-1:0] r_en,    n_en;
    logic [sfga_pkg::BOARDS-1:0] r_fresh, n_fresh;
    logic [sfga_pkg::POS_W-1:0]  r_pos,   n_pos;
    logic [7:0]                  r_held,  n_held;
    logic                        w_busy;
    logic                        w_in_fire;
    logic                        w_cfg_fire;
    logic                        w_active;
    logic                        w_in_data;
    logic [sfga_pkg::POS_W-1:0]  w_k;
    logic [sfga_pkg::BOARDS-1:0] w_fresh_set;
    sfga_pkg::t_wr_req           w_wr;
    sfga_pkg::t_rd_req           w_rd;
    sfga_pkg::t_scan_ctrl        w_ctrl;
    logic [sfga_pkg::VAL_W-1:0]  w_rd_data;

    assign o_in_ready  = !w_busy;
    assign o_cfg_ready = !w_busy;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_cfg_fire  = i_cfg_valid && o_cfg_ready;

    // frame position decode
    assign w_active    = r_en[i_in_word.board_id];
    assign w_in_data   = (r_pos >= sfga_pkg::POS_W'(2))
                         && (r_pos < sfga_pkg::POS_W'(sfga_pkg::FRAME_DATA_END));
    assign w_k         = r_pos - sfga_pkg::POS_W'(2);
    assign w_fresh_set = r_fresh | (sfga_pkg::BOARDS'(1) << i_in_word.board_id);

    // frame parser and round tracking
    always_comb begin
        n_en           = r_en;
        n_fresh        = r_fresh;
        n_pos          = r_pos;
        n_held         = r_held;
        w_wr.en        = 1'b0;
        w_wr.addr      = sfga_pkg::IDX_W'(i_in_word.board_id * sfga_pkg::CH_PER_BOARD
                                          + (w_k >> 1));
        w_wr.data      = {i_in_word.data_byte, r_held};
        w_ctrl.start   = 1'b0;
        w_ctrl.en_mask = r_en;

        if (w_in_fire) begin
            if (w_active) begin
                if (w_in_data) begin
                    if (!w_k[0]) begin
                        n_held = i_in_word.data_byte;
                    end else begin
                        w_wr.en = 1'b1;
                    end
                end
                if (r_pos < sfga_pkg::POS_W'(sfga_pkg::FRAME_DATA_END)) begin
                    n_pos = r_pos + 1'b1;
                end
            end
            if (i_in_word.frame_end) begin
                n_pos  = '0;
                n_held = '0;
                if (w_active) begin
                    if (w_fresh_set == r_en) begin
                        n_fresh      = '0;
                        w_ctrl.start = 1'b1;
                    end else begin
                        n_fresh = w_fresh_set;
                    end
                end
            end
        end

        // enable mask write drops fresh flags of disabled boards
        if (w_cfg_fire) begin
            n_en    = i_cfg_data;
            n_fresh = n_fresh & i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en    <= sfga_pkg::BOARD_MASK_RST;
            r_fresh <= '0;
            r_pos   <= '0;
            r_held  <= '0;
        end else begin
            r_en    <= n_en;
            r_fresh <= n_fresh;
            r_pos   <= n_pos;
            r_held  <= n_held;
        end
    end

    // channel reading store
    sfga_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd      (w_rd),
        .o_rd_data (w_rd_data)
    );

    // maximum search and result register
    sfga_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_busy      (w_busy),
        .o_rd        (w_rd),
        .i_rd_data   (w_rd_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

>>> bench/sensor_frame_gather_argmax_unit_tb.sv
`timescale 1ns / 1ps

module sensor_frame_gather_argmax_unit_tb;

    localparam int SETTLE_CYCLES = 30;
    localparam int TAIL_CYCLES   = 40;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int ACTIVE_WORDS  = 1500;

    // kinds of entries in the sender's schedule
    typedef enum logic [1:0] {
        STEP_WORD,
        STEP_ENABLE,
        STEP_DRAIN,
        STEP_HOLD
    } t_step_kind;

    typedef struct {
        t_step_kind                  kind;
        sfga_pkg::t_in_word          word;
        logic [sfga_pkg::BOARDS-1:0] mask;
    } t_step;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_in_valid  = 1'b0;
    logic                        o_in_ready;
    sfga_pkg::t_in_word          i_in_word   = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    sfga_pkg::t_out_word         o_out_word;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [sfga_pkg::BOARDS-1:0] i_cfg_data  = '0;

    logic                        hold_kick   = 1'b0;

    t_step                       pending_steps[$];
    sfga_pkg::t_out_word         expected_peaks[$];
    int                          mismatch_count = 0;
    int                          cycle_count    = 0;

    // shadow copy of the block state
    logic [sfga_pkg::VAL_W-1:0]  shadow_reading[sfga_pkg::TOTAL_CH];
    logic [sfga_pkg::BOARDS-1:0] shadow_fresh;
    logic [sfga_pkg::BOARDS-1:0] shadow_enable;
    int unsigned                 shadow_pos;
    logic [7:0]                  shadow_low;

    // stimulus generation bookkeeping
    logic [sfga_pkg::BOARDS-1:0] plan_mask   = sfga_pkg::BOARD_MASK_RST;
    int                          plan_active = 0;

    sensor_frame_gather_argmax_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        end
    endtask

    // enable mask write: boards that drop out lose their fresh bit
    task automatic apply_enable(input logic [sfga_pkg::BOARDS-1:0] mask);
        shadow_enable = mask;
        shadow_fresh  = shadow_fresh & mask;
    endtask

    // one accepted byte word; a completed round queues the expected peak
    task automatic absorb_byte(input sfga_pkg::t_in_word w);
        int unsigned         board;
        int unsigned         slot;
        logic                active;
        sfga_pkg::t_out_word peak;
        board  = w.board_id;
        active = (board < sfga_pkg::BOARDS) && shadow_enable[board];
        if (active) begin
            if (shadow_pos >= 2 && shadow_pos < sfga_pkg::FRAME_DATA_END) begin
                if (((shadow_pos - 2) % 2) == 0) begin
                    shadow_low = w.data_byte;
                end else begin
                    slot = board * sfga_pkg::CH_PER_BOARD + (shadow_pos - 2) / 2;
                    shadow_reading[slot] = {w.data_byte, shadow_low};
                end
            end
            if (shadow_pos < sfga_pkg::FRAME_DATA_END) shadow_pos++;
        end
        if (!w.frame_end) return;
        shadow_pos = 0;
        shadow_low = '0;
        if (!active) return;
        shadow_fresh[board] = 1'b1;
        if (shadow_fresh != shadow_enable) return;
        shadow_fresh = '0;
        // first channel with the strictly largest reading wins
        peak = '0;
        for (int i = 0; i < sfga_pkg::TOTAL_CH; i++) begin
            if (shadow_enable[i / sfga_pkg::CH_PER_BOARD]
                && shadow_reading[i] > peak.max_value) begin
                peak.max_value   = shadow_reading[i];
                peak.max_channel = 4'(i);
            end
        end
        expected_peaks.push_back(peak);
    endtask

    task automatic queue_word(input logic [sfga_pkg::BOARD_W-1:0] board,
                              input logic [7:0] data, input bit last);
        t_step s;
        s.kind            = STEP_WORD;
        s.word.board_id   = board;
        s.word.data_byte  = data;
        s.word.frame_end  = last;
        s.mask            = '0;
        pending_steps.push_back(s);
        if (plan_mask[board]) plan_active++;
    endtask

    task automatic queue_marker(input t_step_kind kind);
        t_step s;
        s.kind = kind;
        s.word = '0;
        s.mask = '0;
        pending_steps.push_back(s);
    endtask

    // mask writes only go out once the block has drained
    task automatic queue_enable(input logic [sfga_pkg::BOARDS-1:0] mask);
        t_step s;
        queue_marker(STEP_DRAIN);
        s.kind = STEP_ENABLE;
        s.word = '0;
        s.mask = mask;
        pending_steps.push_back(s);
        plan_mask = mask;
    endtask

    function automatic logic [sfga_pkg::VAL_W-1:0] pick_reading(input bit flat);
        if (flat) return sfga_pkg::VAL_W'($urandom_range(0, 2));
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return sfga_pkg::VAL_W'($urandom);
        endcase
    endfunction

    // reference word, readings, then filler; cut to nbytes with the end flag on the last
    task automatic queue_frame(input logic [sfga_pkg::BOARD_W-1:0] board, input int nbytes);
        logic [7:0]                 stream[$];
        logic [sfga_pkg::VAL_W-1:0] r;
        bit                         flat;
        flat = ($urandom_range(0, 3) == 0);
        stream.push_back(8'($urandom));
        stream.push_back(8'($urandom));
        for (int c = 0; c < sfga_pkg::CH_PER_BOARD; c++) begin
            r = pick_reading(flat);
            stream.push_back(r[7:0]);
            stream.push_back(r[15:8]);
        end
        while (stream.size() < nbytes) stream.push_back(8'($urandom));
        for (int k = 0; k < nbytes; k++) begin
            queue_word(board, stream[k], k == nbytes - 1);
        end
    endtask

    task automatic queue_round();
        logic [sfga_pkg::BOARD_W-1:0] first;
        logic [sfga_pkg::BOARD_W-1:0] board;
        int                           len;
        first = sfga_pkg::BOARD_W'($urandom_range(0, 1));
        for (int n = 0; n < sfga_pkg::BOARDS; n++) begin
            board = first ^ sfga_pkg::BOARD_W'(n);
            if (plan_mask[board] || $urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 9))
                    0:       len = $urandom_range(1, sfga_pkg::FRAME_DATA_END - 1);
                    1:       len = $urandom_range(sfga_pkg::FRAME_DATA_END + 1,
                                                  sfga_pkg::FRAME_DATA_END + 8);
                    default: len = sfga_pkg::FRAME_DATA_END;
                endcase
                queue_frame(board, len);
            end
        end
    endtask

    // sender: bursts with random gaps, fed from the schedule
    always @(posedge i_clk) begin : drive
        logic                        nv_in;
        logic                        nv_cfg;
        logic                        n_kick;
        sfga_pkg::t_in_word          n_word;
        logic [sfga_pkg::BOARDS-1:0] n_cfg;
        int                          settle_left;
        int                          burst_left;
        int                          gap_left;
        t_step                       s;
        nv_in  = i_in_valid;
        nv_cfg = i_cfg_valid;
        n_kick = 1'b0;
        n_word = i_in_word;
        n_cfg  = i_cfg_data;
        if (!i_rst_n) begin
            nv_in       = 1'b0;
            nv_cfg      = 1'b0;
            settle_left = 0;
            burst_left  = 0;
            gap_left    = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                absorb_byte(i_in_word);
                nv_in = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_enable(i_cfg_data);
                nv_cfg = 1'b0;
            end
            if (!nv_in && !nv_cfg) begin
                if (settle_left > 0) begin
                    settle_left--;
                end else if (pending_steps.size() > 0) begin
                    s = pending_steps[0];
                    case (s.kind)
                        STEP_WORD: begin
                            if (gap_left > 0) begin
                                gap_left--;
                            end else begin
                                n_word = s.word;
                                nv_in  = 1'b1;
                                void'(pending_steps.pop_front());
                                if (burst_left > 0) burst_left--;
                                if (burst_left == 0) begin
                                    burst_left = ($urandom_range(0, 4) == 0) ?
                                                 $urandom_range(50, 200) : $urandom_range(1, 12);
                                    gap_left   = ($urandom_range(0, 3) == 0) ?
                                                 0 : $urandom_range(1, 10);
                                end
                            end
                        end
                        STEP_ENABLE: begin
                            n_cfg  = s.mask;
                            nv_cfg = 1'b1;
                            void'(pending_steps.pop_front());
                        end
                        STEP_DRAIN: begin
                            // wait for every peak, then let the scan logic go quiet
                            if (expected_peaks.size() == 0 && !o_out_valid) begin
                                settle_left = SETTLE_CYCLES;
                                void'(pending_steps.pop_front());
                            end
                        end
                        STEP_HOLD: begin
                            n_kick = 1'b1;
                            void'(pending_steps.pop_front());
                        end
                        default: void'(pending_steps.pop_front());
                    endcase
                end
            end
        end
        i_in_valid  <= nv_in;
        i_in_word   <= n_word;
        i_cfg_valid <= nv_cfg;
        i_cfg_data  <= n_cfg;
        hold_kick   <= n_kick;
    end

    // receiver: short stalls, long clean runs, and one long hold-off on request
    always @(posedge i_clk) begin : receive
        int   hold_left;
        int   stall_left;
        int   run_left;
        logic nr;
        if (!i_rst_n) begin
            hold_left  = 0;
            stall_left = 0;
            run_left   = 0;
            nr         = 1'b0;
        end else begin
            if (hold_kick) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                nr = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                nr = 1'b0;
            end else begin
                nr = 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    run_left   = ($urandom_range(0, 3) == 0) ?
                                 $urandom_range(40, 150) : $urandom_range(0, 8);
                    stall_left = $urandom_range(0, 6);
                end
            end
        end
        i_out_ready <= nr;
    end

    // result check against the oldest expected peak
    always @(posedge i_clk) begin : check
        sfga_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_peaks.size() == 0) begin
                report_mismatch("unexpected result word, channel", o_out_word.max_channel, 0);
            end else begin
                want = expected_peaks.pop_front();
                if (o_out_word.max_channel !== want.max_channel) begin
                    report_mismatch("max_channel", o_out_word.max_channel, want.max_channel);
                end
                if (o_out_word.max_value !== want.max_value) begin
                    report_mismatch("max_value", o_out_word.max_value, want.max_value);
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : main
        bit hold_queued;
        hold_queued = 1'b0;
        for (int i = 0; i < sfga_pkg::TOTAL_CH; i++) shadow_reading[i] = '0;
        shadow_fresh  = '0;
        shadow_enable = sfga_pkg::BOARD_MASK_RST;
        shadow_pos    = 0;
        shadow_low    = '0;

        // empty store: round closes with channel 0, value 0
        queue_word(0, 8'h00, 1'b0);
        queue_word(0, 8'hFF, 1'b1);
        queue_word(1, 8'h00, 1'b1);
        // board 1 full-scale reading on its first channel, dangling low byte at the end
        queue_word(1, 8'h5A, 1'b0);
        queue_word(1, 8'hA5, 1'b0);
        queue_word(1, 8'hFF, 1'b0);
        queue_word(1, 8'hFF, 1'b0);
        queue_word(1, 8'h34, 1'b1);
        // board 0 short frame, reading 1 on channel 0
        queue_word(0, 8'h00, 1'b0);
        queue_word(0, 8'h00, 1'b0);
        queue_word(0, 8'h01, 1'b0);
        queue_word(0, 8'h00, 1'b0);
        queue_word(0, 8'h77, 1'b1);
        // disabled board words are ignored
        queue_enable(2'b01);
        queue_word(1, 8'hFF, 1'b0);
        queue_word(1, 8'hFF, 1'b0);
        queue_word(1, 8'hFF, 1'b1);
        queue_word(0, 8'h00, 1'b1);
        // disabling a board drops its fresh bit
        queue_enable(2'b11);
        queue_word(0, 8'h00, 1'b1);
        queue_enable(2'b10);
        queue_word(1, 8'h00, 1'b1);
        // nothing enabled: no result at all
        queue_enable(2'b00);
        queue_word(0, 8'hFF, 1'b1);
        queue_word(1, 8'hFF, 1'b1);
        queue_enable(2'b11);

        // random part: mostly whole rounds, some noise and mask changes
        while (plan_active < ACTIVE_WORDS) begin
            case ($urandom_range(0, 15))
                0: begin
                    case ($urandom_range(0, 4))
                        0:       queue_enable(2'b00);
                        1:       queue_enable(2'b01);
                        2:       queue_enable(2'b10);
                        default: queue_enable(2'b11);
                    endcase
                end
                1: queue_marker(STEP_DRAIN);
                2: begin
                    repeat ($urandom_range(1, 6)) begin
                        queue_word(sfga_pkg::BOARD_W'($urandom_range(0, 1)), 8'($urandom),
                                   $urandom_range(0, 3) == 0);
                    end
                end
                default: queue_round();
            endcase
            if (!hold_queued && plan_active >= 500) begin
                queue_marker(STEP_HOLD);
                hold_queued = 1'b1;
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (pending_steps.size() > 0 || i_in_valid || i_cfg_valid ||
                   expected_peaks.size() > 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_peaks.size() > 0) begin
            report_mismatch("results never delivered", expected_peaks.size(), 0);
        end
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/sfga_pkg.sv
hw/rtl/sfga_store.sv
hw/rtl/sfga_scan.sv
hw/rtl/sensor_frame_gather_argmax_unit.sv
bench/sensor_frame_gather_argmax_unit_tb.sv
